// ----- rtl/sws_pkg.sv -----
// sws_pkg: shared widths, field codes and the command/status structs
// used between the search controller and the search datapath
// no dependencies
package sws_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 14;
    localparam int INDEX_W = 13;

    // request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_en;      // write the request word into the table
        logic start_query;  // latch key, set bounds, issue first read
        logic step;         // compare read word and narrow the bounds
    } sws_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;        // saturated entry count is zero
        logic hit;          // key equals the word just read
        logic last;         // midpoint has reached the lower bound
    } sws_stat_t;

endpackage

// ----- rtl/sws_dp.sv -----
// sws_dp: word table memory, search bounds and string compare
// depends on sws_pkg
module sws_dp
    import sws_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [COUNT_W-1:0]  cfg_data,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic [WORD_W-1:0]   word_bytes,
    input  sws_cmd_t            cmd,
    output sws_stat_t           stat
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW    = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int SW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int EW    = (XW > CNT_W) ? XW : CNT_W;

    // zero every byte after the first zero byte
    function automatic logic [WORD_W-1:0] trim_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] res;
        logic              live;
        res  = '0;
        live = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            if (w[i*8 +: 8] == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                res[i*8 +: 8] = w[i*8 +: 8];
            end
        end
        return res;
    endfunction

    logic [WORD_W-1:0]  mem [TABLE_DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [WORD_W-1:0]  key_reg;
    logic [COUNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0]   lower_reg, lower_next;
    logic [CNT_W-1:0]   upper_reg, upper_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   sat_count;
    logic [CNT_W:0]     bound_sum;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [XW-1:0]      wr_idx_ext;
    logic [SW-1:0]      count_ext;
    logic               wr_in_range;
    logic [WORD_W-1:0]  entry_trim;
    logic               key_lt;

    // entry count register; the user writes it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // count above depth saturates to depth
    assign count_ext = SW'(entry_count_reg);
    assign sat_count = (count_ext > SW'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(count_ext);

    assign wr_idx_ext  = XW'(entry_index);
    assign wr_in_range = EW'(wr_idx_ext) < EW'(TABLE_DEPTH);
    assign wr_addr     = wr_idx_ext[AW-1:0];

    assign entry_trim = trim_word(rd_data_reg);
    assign key_lt     = key_reg < entry_trim;

    assign stat.empty = (sat_count == '0);
    assign stat.hit   = (key_reg == entry_trim);
    assign stat.last  = (mid_reg == lower_reg);

    always_comb
    begin
        lower_next = lower_reg;
        upper_next = upper_reg;
        if (cmd.start_query)
        begin
            lower_next = '0;
            upper_next = sat_count;
        end
        else if (cmd.step)
        begin
            if (key_lt)
            begin
                upper_next = mid_reg;
            end
            else
            begin
                lower_next = mid_reg;
            end
        end
        bound_sum = {1'b0, upper_next} + {1'b0, lower_next};
        mid_next  = bound_sum[CNT_W:1];
    end

    assign rd_addr = mid_next[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= '0;
            mid_reg   <= '0;
        end
        else
        begin
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            mid_reg   <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            key_reg <= trim_word(word_bytes);
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && wr_in_range)
        begin
            mem[wr_addr] <= word_bytes;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ----- rtl/sws_ctrl.sv -----
// sws_ctrl: request handshake, search sequencing and result register
// depends on sws_pkg
module sws_ctrl
    import sws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      kind,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      found,
    output sws_cmd_t  cmd,
    input  sws_stat_t stat
);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   found_reg, found_next;
    logic   accept;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && ((kind == KIND_LOAD) || slot_free);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd.load_en     = accept && (kind == KIND_LOAD);
        cmd.start_query = accept && (kind == KIND_QUERY);
        cmd.step        = (state_reg == ST_SEARCH) && !(stat.hit || stat.last);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start_query)
                begin
                    if (stat.empty)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (stat.hit || stat.last)
                begin
                    out_valid_next = 1'b1;
                    found_next     = stat.hit;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;

endmodule

// ----- rtl/sorted_word_table_search.sv -----
// sorted_word_table_search: top level, sorted word table with binary search
// depends on sws_pkg, sws_ctrl, sws_dp
//
//  channel   handshake              payload
//  input     in_valid / in_ready    kind, entry_index, word_bytes
//  result    out_valid / out_ready  found (one per query request)
//  config    cfg_valid / cfg_ready  cfg_data (entry_count)
//
// a load request is written into the table when accepted; a query makes one
// midpoint compare per step, about log2(entry_count) + 1 compares, and takes
// no new request until it ends; the loop is bounded by the single table read
// port, one registered read per compare
// reset clears the entry count and control only; table words are undefined
// until loaded
// the result sits in an output register; loads are still taken while it
// waits, a new query waits until the slot frees
module sorted_word_table_search
    import sws_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192
)
(
    input  logic               clk,
    input  logic               rst_n,
    // config write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [WORD_W-1:0]  word_bytes,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found
);

    sws_cmd_t  cmd;
    sws_stat_t stat;

    // config register is always writable
    assign cfg_ready = 1'b1;

    sws_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .cmd       (cmd),
        .stat      (stat)
    );

    sws_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .word_bytes  (word_bytes),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ----- verif/sorted_word_table_search_tb.sv -----
`timescale 1ns / 100ps
// sorted_word_table_search_tb: self-checking bench for the sorted word table search
// depends on sws_pkg and sorted_word_table_search; nothing else is read
module sorted_word_table_search_tb;

    import sws_pkg::*;

    localparam int TABLE_DEPTH   = 8192;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake anywhere
    localparam int HOLD_AT       = 250;   // query count that starts the long sink stall
    localparam int HOLD_CYCLES   = 400;
    localparam int CALM_FROM     = 100;   // query window with no idling on either side
    localparam int CALM_TO       = 180;
    localparam int MAX_RANK      = 65000; // ranks map onto two nonzero leading bytes

    typedef enum logic [1:0] {STEP_REQUEST, STEP_CONFIG, STEP_DRAIN} step_kind_t;

    typedef struct packed {
        step_kind_t         what;
        logic               kind;
        logic [INDEX_W-1:0] idx;
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
    } step_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data    = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               kind        = KIND_LOAD;
    logic [INDEX_W-1:0] entry_index = '0;
    logic [WORD_W-1:0]  word_bytes  = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               found;

    // stimulus plan, consumed in order by the driver
    step_t              pending_q[$];
    // planning copy of the table, used only to pick words worth querying
    logic [WORD_W-1:0]  plan_table [TABLE_DEPTH];
    int unsigned        plan_span;

    // predictor state, updated as requests and register writes are accepted
    logic [WORD_W-1:0]  model_table [TABLE_DEPTH];
    logic [COUNT_W-1:0] model_count;
    logic               expected_found[$];

    int                 queries_taken;
    int                 mismatches;
    int                 settle_left;
    int                 hold_left;
    logic               hold_done;
    int                 quiet_cycles;
    step_t              head;
    logic               offer_req;
    logic               offer_cfg;
    logic               expected_bit;

    sorted_word_table_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .entry_index (entry_index),
        .word_bytes  (word_bytes),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // string view of a packed word: everything after the first nul is dropped
    function automatic logic [WORD_W-1:0] strip_tail(logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        logic              stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (w[i*8 +: 8] == 8'h00)
                stop = 1'b1;
            if (!stop)
                r[i*8 +: 8] = w[i*8 +: 8];
        end
        return r;
    endfunction

    // binary search over [0, count), count saturated at the depth; once the
    // midpoint meets the lower bound the remaining entry gets a final compare
    function automatic logic predict_found(logic [WORD_W-1:0] key);
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       mid;
        logic [WORD_W-1:0] probe;
        logic [WORD_W-1:0] entry;
        probe = strip_tail(key);
        lo    = 0;
        hi    = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
        if (hi == 0)
            return 1'b0;
        mid = (lo + hi) / 2;
        while (mid != lo)
        begin
            entry = strip_tail(model_table[mid]);
            if (probe == entry)
                return 1'b1;
            if (probe < entry)
                hi = mid;
            else
                lo = mid;
            mid = (lo + hi) / 2;
        end
        return probe == strip_tail(model_table[mid]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------

    // word whose first two bytes encode the rank, so rank order is string
    // order; a random tail follows, with random junk behind the terminator
    function automatic logic [WORD_W-1:0] ranked_word(int unsigned rank);
        logic [WORD_W-1:0] w;
        int unsigned       len;
        w          = {$urandom, $urandom};
        w[63:56]   = 8'(1 + rank / 255);
        w[55:48]   = 8'(1 + rank % 255);
        len        = $urandom_range(2, 8);
        for (int i = 2; i < 8; i++)
        begin
            if (i < len)
                w[(7-i)*8 +: 8] = 8'($urandom_range(1, 255));
            else if (i == len)
                w[(7-i)*8 +: 8] = 8'h00;
        end
        return w;
    endfunction

    // same string, fresh junk after the terminator
    function automatic logic [WORD_W-1:0] fresh_tail(logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        logic              past;
        r    = {$urandom, $urandom};
        past = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!past)
                r[i*8 +: 8] = w[i*8 +: 8];
            if (w[i*8 +: 8] == 8'h00)
                past = 1'b1;
        end
        return r;
    endfunction

    task automatic push_request(input logic k, input logic [INDEX_W-1:0] idx,
                                input logic [WORD_W-1:0] w);
        step_t s;
        s      = '0;
        s.what = STEP_REQUEST;
        s.kind = k;
        s.idx  = idx;
        s.word = w;
        pending_q.push_back(s);
        if (k == KIND_LOAD)
            plan_table[idx] = w;
    endtask

    // register writes only go in once the block has drained
    task automatic push_config(input logic [COUNT_W-1:0] c);
        step_t s;
        s       = '0;
        s.what  = STEP_DRAIN;
        pending_q.push_back(s);
        s.what  = STEP_CONFIG;
        s.count = c;
        pending_q.push_back(s);
        plan_span = (c > TABLE_DEPTH) ? TABLE_DEPTH : c;
    endtask

    // ascending words into positions 0 .. n-1
    task automatic load_sorted(input int unsigned n);
        int unsigned rank;
        int unsigned gap_max;
        gap_max = MAX_RANK / n;
        rank    = $urandom_range(0, gap_max);
        for (int unsigned i = 0; i < n; i++)
        begin
            push_request(KIND_LOAD, INDEX_W'(i), ranked_word(rank));
            rank = rank + $urandom_range(1, gap_max);
        end
    endtask

    // words held in the table, plus near misses, noise and extremes;
    // a few loads rewrite an entry with the same string to keep the order
    task automatic query_mix(input int unsigned n);
        int unsigned       pick;
        int unsigned       idx;
        logic [WORD_W-1:0] w;
        logic              grown;
        for (int unsigned q = 0; q < n; q++)
        begin
            pick = $urandom_range(0, 99);
            idx  = (plan_span == 0) ? 0 : $urandom_range(0, plan_span - 1);
            w    = (plan_span == 0) ? {$urandom, $urandom} : plan_table[idx];
            if (pick < 5)
                push_request(KIND_LOAD, INDEX_W'(idx), fresh_tail(w));
            else if (pick < 50)
                push_request(KIND_QUERY, INDEX_W'($urandom), fresh_tail(w));
            else if (pick < 70)
            begin
                // one character longer than a stored word
                w     = fresh_tail(w);
                grown = 1'b0;
                for (int b = 7; b >= 0; b--)
                begin
                    if (!grown && w[b*8 +: 8] == 8'h00)
                    begin
                        w[b*8 +: 8] = 8'($urandom_range(1, 255));
                        grown       = 1'b1;
                    end
                end
                push_request(KIND_QUERY, INDEX_W'($urandom), w);
            end
            else if (pick < 85)
                push_request(KIND_QUERY, INDEX_W'($urandom),
                             ranked_word($urandom_range(0, MAX_RANK)));
            else if (pick < 95)
                push_request(KIND_QUERY, INDEX_W'($urandom), {$urandom, $urandom});
            else
            begin
                w = {$urandom, $urandom};
                case ($urandom_range(0, 2))
                    0:       w = '0;
                    1:       w = '1;
                    default: w[55:48] = 8'h00;  // one character word
                endcase
                push_request(KIND_QUERY, INDEX_W'($urandom), w);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // request and register driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            cfg_valid     <= 1'b0;
            kind          <= KIND_LOAD;
            entry_index   <= '0;
            word_bytes    <= '0;
            cfg_data      <= '0;
            queries_taken <= 0;
            model_count    = '0;
            settle_left    = SETTLE_CYCLES;
        end
        else
        begin
            // predictions are made in acceptance order
            if (in_valid && in_ready)
            begin
                if (kind == KIND_QUERY)
                begin
                    expected_found.push_back(predict_found(word_bytes));
                    queries_taken <= queries_taken + 1;
                end
                else if (entry_index < TABLE_DEPTH)
                begin
                    model_table[entry_index] = word_bytes;
                end
            end
            if (cfg_valid && cfg_ready)
                model_count = cfg_data;

            if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready))
            begin
                // payload held until taken
            end
            else
            begin
                offer_req = 1'b0;
                offer_cfg = 1'b0;
                if (pending_q.size() != 0)
                begin
                    head = pending_q[0];
                    if (head.what == STEP_DRAIN)
                    begin
                        // sender pause: nothing outstanding, then let the block settle
                        if (expected_found.size() != 0)
                            settle_left = SETTLE_CYCLES;
                        else if (settle_left != 0)
                            settle_left = settle_left - 1;
                        else
                        begin
                            head        = pending_q.pop_front();
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                    else if ((queries_taken >= CALM_FROM && queries_taken < CALM_TO)
                             || $urandom_range(0, 99) >= 33)
                    begin
                        head = pending_q.pop_front();
                        if (head.what == STEP_CONFIG)
                        begin
                            offer_cfg = 1'b1;
                            cfg_data <= head.count;
                        end
                        else
                        begin
                            offer_req    = 1'b1;
                            kind        <= head.kind;
                            entry_index <= head.idx;
                            word_bytes  <= head.word;
                        end
                    end
                end
                in_valid  <= offer_req;
                cfg_valid <= offer_cfg;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and sink
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            mismatches = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_found.size() == 0)
                begin
                    $error("found: result with no query outstanding, actual %0b", found);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    expected_bit = expected_found.pop_front();
                    if (found !== expected_bit)
                    begin
                        $error("found mismatch: expected %0b, actual %0b", expected_bit, found);
                        mismatches = mismatches + 1;
                    end
                end
            end

            // one long stall so the result slot fills and backs up the input
            if (!hold_done && queries_taken >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left  = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (queries_taken >= CALM_FROM && queries_taken < CALM_TO)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // test plan
    // ------------------------------------------------------------------
    initial
    begin
        plan_span = 0;

        // empty table straight after reset
        push_request(KIND_QUERY, '1, 64'h4100_0000_0000_0000);
        push_request(KIND_QUERY, '0, '1);
        // index extremes, largest word as the single entry
        push_request(KIND_LOAD, INDEX_W'(TABLE_DEPTH - 1), '0);
        push_request(KIND_LOAD, '0, '1);
        push_config(COUNT_W'(1));
        push_request(KIND_QUERY, '0, '1);
        push_request(KIND_QUERY, '1, '0);
        push_request(KIND_QUERY, '0, 64'h4100_0000_0000_0000);
        // empty string as the single entry, junk behind the query terminator
        push_request(KIND_LOAD, '0, '0);
        push_request(KIND_QUERY, '1, 64'h00FF_FFFF_FFFF_FFFF);
        push_request(KIND_QUERY, '0, 64'h0100_0000_0000_0000);
        // junk after the terminator on both sides
        push_request(KIND_LOAD, '0, 64'h4142_00FF_EEDD_CCBB);
        push_request(KIND_QUERY, '0, 64'h4142_0078_797A_0000);
        push_request(KIND_QUERY, '0, 64'h4142_4300_0000_0000);
        push_request(KIND_QUERY, '0, 64'h4100_4200_0000_0000);
        // two entries
        push_request(KIND_LOAD, 13'd1, 64'h4200_1234_5678_9ABC);
        push_config(COUNT_W'(2));
        push_request(KIND_QUERY, '0, 64'h4142_0000_0000_0000);
        push_request(KIND_QUERY, '0, 64'h4200_0000_0000_0000);
        push_request(KIND_QUERY, '0, 64'h4300_0000_0000_0000);

        // small sorted tables
        load_sorted(3);
        push_config(COUNT_W'(3));
        query_mix(40);
        load_sorted(5);
        push_config(COUNT_W'(5));
        query_mix(40);
        push_config(COUNT_W'(1));
        query_mix(30);
        load_sorted(17);
        push_config(COUNT_W'(17));
        query_mix(50);
        load_sorted(64);
        push_config(COUNT_W'(64));
        query_mix(50);

        // unsorted table, searched as is
        for (int i = 0; i < 12; i++)
            push_request(KIND_LOAD, INDEX_W'(i), ranked_word($urandom_range(0, MAX_RANK)));
        push_config(COUNT_W'(12));
        query_mix(50);

        // larger table, then a shorter count over it and an empty one
        load_sorted(240);
        push_config(COUNT_W'(240));
        query_mix(60);
        push_config(COUNT_W'(150));
        query_mix(40);
        push_config('0);
        query_mix(20);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || expected_found.size() != 0 || in_valid || cfg_valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_found.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
